// ===== rtl/rgb_to_yuv9_converter_defines.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef RGB_TO_YUV9_CONVERTER_DEFINES_SVH
`define RGB_TO_YUV9_CONVERTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RGBYUV9_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RGBYUV9_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, always active
`define RGBYUV9_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rgbyuv9_pkg.sv =====
// types, constants and helpers for the rgb to yuv9 converter
// no dependencies
package rgbyuv9_pkg;

  localparam int MAX_BLOCK_COLUMNS_DEF = 512;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 10;
  localparam int WIDTH_W    = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FORMAT = 8'd1;

  localparam logic FMT_RGB555 = 1'b0;
  localparam logic FMT_BGR24  = 1'b1;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 10'd160;
  localparam logic               FORMAT_RESET = FMT_BGR24;

  localparam logic [14:0] Y_COEF_R = 15'd9765;
  localparam logic [14:0] Y_COEF_G = 15'd19169;
  localparam logic [14:0] Y_COEF_B = 15'd3801;
  localparam int          Y_SHIFT  = 15;

  localparam logic signed [15:0] V_COEF_R = -16'sd5536;
  localparam logic signed [15:0] V_COEF_G = -16'sd10847;
  localparam logic signed [15:0] V_COEF_B = 16'sd16383;
  localparam logic signed [15:0] U_COEF_R = 16'sd16383;
  localparam logic signed [15:0] U_COEF_G = -16'sd13663;
  localparam logic signed [15:0] U_COEF_B = -16'sd2720;
  localparam int                 C_SHIFT  = 19;
  localparam logic [7:0]         C_OFFSET = 8'd128;

  localparam logic [4:0] RGB555_MASK = 5'h1F;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [11:0] r;
    logic [11:0] g;
    logic [11:0] b;
  } sums_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
  } result_t;

  function automatic rgb_t decode_pixel(input logic [23:0] word, input logic fmt);
    rgb_t p;
    if (fmt == FMT_RGB555) begin
      p.b = {word[4:0] & RGB555_MASK, 3'b000};
      p.g = {word[9:5] & RGB555_MASK, 3'b000};
      p.r = {word[14:10] & RGB555_MASK, 3'b000};
    end else begin
      p.b = word[7:0];
      p.g = word[15:8];
      p.r = word[23:16];
    end
    return p;
  endfunction

endpackage

// ===== rtl/rgbyuv9_color_math.sv =====
// block sum update, luma and chroma arithmetic for one pixel
// depends on rgbyuv9_pkg
module rgbyuv9_color_math (
  input  rgbyuv9_pkg::rgb_t    pix,
  input  rgbyuv9_pkg::sums_t   base,
  input  logic                 close,
  output rgbyuv9_pkg::sums_t   sums,
  output rgbyuv9_pkg::result_t res
);

  logic [22:0]        yr, yg, yb;
  logic [23:0]        ysum;
  logic signed [12:0] sr, sg, sb;
  logic signed [28:0] vr, vg, vb, ur, ug, ub;
  logic signed [30:0] vsum, usum;

  always_comb begin
    sums.r = base.r + 12'(pix.r);
    sums.g = base.g + 12'(pix.g);
    sums.b = base.b + 12'(pix.b);
  end

  always_comb begin
    yr   = 23'(pix.r) * 23'(rgbyuv9_pkg::Y_COEF_R);
    yg   = 23'(pix.g) * 23'(rgbyuv9_pkg::Y_COEF_G);
    yb   = 23'(pix.b) * 23'(rgbyuv9_pkg::Y_COEF_B);
    ysum = 24'(yr) + 24'(yg) + 24'(yb);
  end

  always_comb begin
    sr   = signed'({1'b0, sums.r});
    sg   = signed'({1'b0, sums.g});
    sb   = signed'({1'b0, sums.b});
    vr   = 29'(sr) * 29'(rgbyuv9_pkg::V_COEF_R);
    vg   = 29'(sg) * 29'(rgbyuv9_pkg::V_COEF_G);
    vb   = 29'(sb) * 29'(rgbyuv9_pkg::V_COEF_B);
    ur   = 29'(sr) * 29'(rgbyuv9_pkg::U_COEF_R);
    ug   = 29'(sg) * 29'(rgbyuv9_pkg::U_COEF_G);
    ub   = 29'(sb) * 29'(rgbyuv9_pkg::U_COEF_B);
    vsum = 31'(vr) + 31'(vg) + 31'(vb);
    usum = 31'(ur) + 31'(ug) + 31'(ub);
  end

  always_comb begin
    res.luma         = ysum[rgbyuv9_pkg::Y_SHIFT +: 8];
    res.chroma_valid = close;
    if (close) begin
      res.chroma_u = usum[rgbyuv9_pkg::C_SHIFT +: 8] + rgbyuv9_pkg::C_OFFSET;
      res.chroma_v = vsum[rgbyuv9_pkg::C_SHIFT +: 8] + rgbyuv9_pkg::C_OFFSET;
    end else begin
      res.chroma_u = 8'd0;
      res.chroma_v = 8'd0;
    end
  end

endmodule

// ===== rtl/rgb_to_yuv9_converter.sv =====
// result path from item accept to result valid: input stage register, then result register
// throughput: one item per cycle while the output is not stalled, bound by the single read-modify-write
//   of the block-column sum memory, with same-edge forwarding from write to read
// reset: clears position counters, stage valids and config (width 160, byte format);
//   the block-column sum memory is not cleared
// top level of the rgb to yuv9 converter; uses rgbyuv9_pkg and rgbyuv9_color_math
module rgb_to_yuv9_converter #(
  parameter int MAX_BLOCK_COLUMNS = rgbyuv9_pkg::MAX_BLOCK_COLUMNS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgbyuv9_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgbyuv9_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [23:0]                         in_pixel_word,
  input  logic                                in_frame_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_luma,
  output logic                                out_chroma_valid,
  output logic [7:0]                          out_chroma_u,
  output logic [7:0]                          out_chroma_v
);

  localparam int BLK_W = (MAX_BLOCK_COLUMNS > 1) ? $clog2(MAX_BLOCK_COLUMNS) : 1;
  localparam int COL_W = BLK_W + 2;
  localparam int WE_W  = BLK_W + 1;
  localparam int WC_W  = (WE_W > rgbyuv9_pkg::WIDTH_W) ? WE_W : rgbyuv9_pkg::WIDTH_W;

  logic [rgbyuv9_pkg::WIDTH_W-1:0] width_r;
  logic                            fmt_r;
  logic [COL_W-1:0]                col_r, col_nxt, col_eff;
  logic [1:0]                      row_r, row_nxt, row_eff;
  logic [WE_W-1:0]                 w_eff;
  logic [WC_W-1:0]                 width_x;
  logic [BLK_W-1:0]                blk_raw, blk;
  logic [COL_W:0]                  col_inc, row_len;

  logic                            accept, s1_fire;
  logic                            s1_valid_r, s1_first_r, s1_close_r;
  rgbyuv9_pkg::rgb_t               s1_pix_r;
  logic [BLK_W-1:0]                s1_blk_r;
  rgbyuv9_pkg::sums_t              rd_data_r, byp_data_r, base, sums_nxt;
  logic                            byp_hit_r;
  rgbyuv9_pkg::sums_t              mem [MAX_BLOCK_COLUMNS];

  logic                            out_valid_r;
  rgbyuv9_pkg::result_t            out_res_r, res_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= rgbyuv9_pkg::WIDTH_RESET;
      fmt_r   <= rgbyuv9_pkg::FORMAT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rgbyuv9_pkg::CFG_IDX_WIDTH:  width_r <= cfg_data[rgbyuv9_pkg::WIDTH_W-1:0];
        rgbyuv9_pkg::CFG_IDX_FORMAT: fmt_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective width and position of the incoming item
  always_comb begin
    width_x = WC_W'(width_r);
    if (width_r == '0) begin
      w_eff = WE_W'(1);
    end else if (width_x > WC_W'(MAX_BLOCK_COLUMNS)) begin
      w_eff = WE_W'(MAX_BLOCK_COLUMNS);
    end else begin
      w_eff = WE_W'(width_x);
    end
    col_eff = in_frame_start ? '0 : col_r;
    row_eff = in_frame_start ? 2'd0 : row_r;
    blk_raw = col_eff[COL_W-1:2];
    if ({1'b0, blk_raw} >= w_eff) begin
      blk = BLK_W'(w_eff - WE_W'(1));
    end else begin
      blk = blk_raw;
    end
    col_inc = {1'b0, col_eff} + (COL_W+1)'(1);
    row_len = {w_eff, 2'b00};
    if (col_inc >= row_len) begin
      col_nxt = '0;
      row_nxt = row_eff + 2'd1;
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row_eff;
    end
  end

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= 2'd0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= rgbyuv9_pkg::decode_pixel(in_pixel_word, fmt_r);
      s1_blk_r   <= blk;
      s1_first_r <= (row_eff == 2'd0) && (col_eff[1:0] == 2'd0);
      s1_close_r <= (row_eff == 2'd3) && (col_eff[1:0] == 2'd3);
      byp_hit_r  <= s1_fire && (s1_blk_r == blk);
      byp_data_r <= sums_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      mem[s1_blk_r] <= sums_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[blk];
    end
  end

  always_comb begin
    if (s1_first_r) begin
      base = '0;
    end else if (byp_hit_r) begin
      base = byp_data_r;
    end else begin
      base = rd_data_r;
    end
  end

  rgbyuv9_color_math u_math (
    .pix   (s1_pix_r),
    .base  (base),
    .close (s1_close_r),
    .sums  (sums_nxt),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_luma         = out_res_r.luma;
  assign out_chroma_valid = out_res_r.chroma_valid;
  assign out_chroma_u     = out_res_r.chroma_u;
  assign out_chroma_v     = out_res_r.chroma_v;

endmodule

// ===== rtl/rgbyuv9_checker.sv =====
// port-level assertions for the rgb to yuv9 converter, bound to the top level
// depends on rgbyuv9_pkg and rgb_to_yuv9_converter_defines.svh
`include "rgb_to_yuv9_converter_defines.svh"

module rgbyuv9_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [rgbyuv9_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [rgbyuv9_pkg::CFG_DATA_W-1:0] cfg_data,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [23:0]                        in_pixel_word,
  input logic                               in_frame_start,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [7:0]                         out_luma,
  input logic                               out_chroma_valid,
  input logic [7:0]                         out_chroma_u,
  input logic [7:0]                         out_chroma_v
);

  `RGBYUV9_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_luma) && $stable(out_chroma_valid) && $stable(out_chroma_u) && $stable(out_chroma_v), "stalled result changed")

  `RGBYUV9_ASSERT_IMPL(a_no_chroma_zero, clk, rst_n, out_valid && !out_chroma_valid, out_chroma_u == 8'd0 && out_chroma_v == 8'd0, "chroma fields nonzero without chroma_valid")

  `RGBYUV9_ASSERT_IMPL(a_empty_accepts, clk, rst_n, !out_valid, in_ready, "input stalled with empty result register")

  `RGBYUV9_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "result valid right after reset")

endmodule

bind rgb_to_yuv9_converter rgbyuv9_checker u_checker (.*);
